// ----- sv/dpit_pkg.sv -----
package dpit_pkg;

  // Width of every tick counter and tick register
  localparam int unsigned TickW = 20;
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // Register reset values
  localparam logic [TickW-1:0] RunTicksRst  = 20'd3000;
  localparam logic [TickW-1:0] CoolTicksRst = 20'd60000;

  // Input opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ACID = 2'd1;
  localparam logic [1:0] OP_BASE = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_RUN_TICKS  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COOL_TICKS = 1'b1;

  typedef struct packed {
    logic             acid_running;
    logic             base_running;
    logic             pump_was_started;
    logic [TickW-1:0] run_elapsed;
    logic             in_cooldown;
    logic [TickW-1:0] cooldown_elapsed;
  } dpit_state_t;

  typedef struct packed {
    logic             acid_drive;
    logic             base_drive;
    logic             cooling_down;
    logic [TickW-1:0] cooldown_left;
    logic             request_refused;
  } dpit_result_t;

  // Saturating increment of a tick counter
  function automatic logic [TickW-1:0] sat_inc(input logic [TickW-1:0] v);
    sat_inc = (v == TickMax) ? TickMax : v + TickW'(1);
  endfunction

endpackage

// ----- sv/dpit_step.sv -----
// Next-state and result logic for one tick or command
module dpit_step (
  input  dpit_pkg::dpit_state_t            cur,
  input  logic [1:0]                       opcode,
  input  logic                             turn_on,
  input  logic [dpit_pkg::TickW-1:0]       run_ticks,
  input  logic [dpit_pkg::TickW-1:0]       cool_ticks,
  output dpit_pkg::dpit_state_t            nxt,
  output dpit_pkg::dpit_result_t           res
);
  import dpit_pkg::*;

  logic             running;
  logic [TickW-1:0] run_inc;
  logic [TickW-1:0] cool_inc;
  logic             auto_stop;
  logic             refused;

  assign running   = cur.acid_running | cur.base_running;
  assign run_inc   = sat_inc(cur.run_elapsed);
  assign cool_inc  = sat_inc(cur.cooldown_elapsed);
  assign auto_stop = running & cur.pump_was_started & (run_inc >= run_ticks);
  assign refused   = turn_on & cur.in_cooldown &
                     ((opcode == OP_ACID) || (opcode == OP_BASE));

  // State update per opcode
  always_comb begin
    nxt = cur;
    unique case (opcode)
      OP_TICK: begin
        if (running && cur.pump_was_started) begin
          nxt.run_elapsed = run_inc;
        end
        if (auto_stop) begin
          // pump_was_started is known set here, so a new cooldown starts unless
          // cool_ticks is zero; it is not advanced on this tick
          nxt.acid_running     = 1'b0;
          nxt.base_running     = 1'b0;
          nxt.pump_was_started = 1'b0;
          nxt.cooldown_elapsed = '0;
          nxt.in_cooldown      = (cool_ticks != '0);
        end else if (cur.in_cooldown) begin
          if (cool_inc >= cool_ticks) begin
            nxt.in_cooldown      = 1'b0;
            nxt.cooldown_elapsed = '0;
          end else begin
            nxt.cooldown_elapsed = cool_inc;
          end
        end
      end
      OP_ACID, OP_BASE: begin
        if (turn_on) begin
          if (!cur.in_cooldown) begin
            nxt.acid_running     = (opcode == OP_ACID);
            nxt.base_running     = (opcode == OP_BASE);
            nxt.run_elapsed      = '0;
            nxt.pump_was_started = 1'b1;
          end
        end else if (opcode == OP_ACID) begin
          nxt.acid_running = 1'b0;
        end else begin
          nxt.base_running = 1'b0;
        end
      end
      OP_STOP: begin
        nxt.acid_running = 1'b0;
        nxt.base_running = 1'b0;
        if (cur.pump_was_started) begin
          nxt.in_cooldown      = 1'b1;
          nxt.cooldown_elapsed = '0;
          nxt.pump_was_started = 1'b0;
        end
      end
      default: nxt = cur;
    endcase
  end

  // Result reflects the state after the update
  always_comb begin
    res.acid_drive      = nxt.acid_running;
    res.base_drive      = nxt.base_running;
    res.cooling_down    = nxt.in_cooldown;
    res.request_refused = refused;
    if (nxt.in_cooldown && (nxt.cooldown_elapsed < cool_ticks)) begin
      res.cooldown_left = cool_ticks - nxt.cooldown_elapsed;
    end else begin
      res.cooldown_left = '0;
    end
  end

endmodule

// ----- sv/dual_pump_interlock_timer.sv -----
// Interlock and run timer for two mutually exclusive dosing pumps (acid and
// base). Each input transfer is one millisecond tick or a command, and each
// produces exactly one result transfer showing the pump drives, the cooldown
// status and whether a turn-on request was refused. The state update is
// combinational logic feeding a result register backed by a one-entry skid
// register, so one item is taken per clock while the result side keeps up;
// in_stall rises only after the skid register has filled under a stalled
// output. The result is registered. The block leaves reset in cooldown.
// Configuration writes are always ready and apply from the next item on.
module dual_pump_interlock_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic                            in_turn_on,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_acid_drive,
  output logic                            out_base_drive,
  output logic                            out_cooling_down,
  output logic [dpit_pkg::TickW-1:0]      out_cooldown_left,
  output logic                            out_request_refused,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpit_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dpit_pkg::TickW-1:0]      cfg_data
);
  import dpit_pkg::*;

  logic [TickW-1:0] run_ticks_r;
  logic [TickW-1:0] cool_ticks_r;
  dpit_state_t      state_r;
  dpit_state_t      state_nxt;
  dpit_result_t     step_res;
  dpit_result_t     out_r;
  dpit_result_t     skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_xfer;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid & ~skid_valid_r;
  assign out_free  = ~out_valid_r | ~out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_ticks_r  <= RunTicksRst;
      cool_ticks_r <= CoolTicksRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RUN_TICKS:  run_ticks_r  <= cfg_data;
        CFG_COOL_TICKS: cool_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dpit_step u_step (
    .cur        (state_r),
    .opcode     (in_opcode),
    .turn_on    (in_turn_on),
    .run_ticks  (run_ticks_r),
    .cool_ticks (cool_ticks_r),
    .nxt        (state_nxt),
    .res        (step_res)
  );

  // Pump and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.acid_running     <= 1'b0;
      state_r.base_running     <= 1'b0;
      state_r.pump_was_started <= 1'b0;
      state_r.run_elapsed      <= '0;
      state_r.in_cooldown      <= 1'b1;
      state_r.cooldown_elapsed <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Result register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_xfer) begin
        out_r <= step_res;
      end
    end else if (in_xfer) begin
      skid_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_acid_drive      = out_r.acid_drive;
  assign out_base_drive      = out_r.base_drive;
  assign out_cooling_down    = out_r.cooling_down;
  assign out_cooldown_left   = out_r.cooldown_left;
  assign out_request_refused = out_r.request_refused;

  // Pumps never run together
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.acid_running && state_r.base_running))
    else $error("both pumps driven");

  // A refused request is only reported while cooling down
  a_refuse_cool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_refused) |-> out_cooling_down)
    else $error("refusal outside cooldown");

  // Remaining cooldown is zero when not cooling down
  a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cooling_down) |-> (out_cooldown_left == '0))
    else $error("cooldown_left nonzero outside cooldown");

  // The skid register only holds data behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without result");

endmodule

// ----- sim/tb_dual_pump_interlock_timer.sv -----
module tb_dual_pump_interlock_timer;
  import dpit_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_opcode;
  logic                in_turn_on;
  logic                out_valid;
  logic                out_stall;
  logic                out_acid_drive;
  logic                out_base_drive;
  logic                out_cooling_down;
  logic [TickW-1:0]    out_cooldown_left;
  logic                out_request_refused;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [TickW-1:0]    cfg_data;

  dual_pump_interlock_timer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_turn_on          (in_turn_on),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_acid_drive      (out_acid_drive),
    .out_base_drive      (out_base_drive),
    .out_cooling_down    (out_cooling_down),
    .out_cooldown_left   (out_cooldown_left),
    .out_request_refused (out_request_refused),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Interlock model: registers and state
  logic [TickW-1:0] run_limit;
  logic [TickW-1:0] cool_limit;
  logic             acid_on;
  logic             base_on;
  logic             armed;
  logic [TickW-1:0] run_cnt;
  logic             in_cool;
  logic [TickW-1:0] cool_cnt;

  // Expected pump status, oldest first
  dpit_result_t pending_status[$];

  int unsigned idle_cap;
  int unsigned items_fed;
  int unsigned status_checked;
  int unsigned refusals;
  int unsigned reg_writes;
  int unsigned fail_count;

  task automatic reset_model();
    run_limit  = RunTicksRst;
    cool_limit = CoolTicksRst;
    acid_on    = 1'b0;
    base_on    = 1'b0;
    armed      = 1'b0;
    run_cnt    = '0;
    in_cool    = 1'b1;
    cool_cnt   = '0;
  endtask

  // Both pumps off; a fresh cooldown only if a pump was started
  task automatic halt_model();
    acid_on = 1'b0;
    base_on = 1'b0;
    if (armed) begin
      in_cool  = 1'b1;
      cool_cnt = '0;
      armed    = 1'b0;
    end
  endtask

  task automatic advance_interlock(input logic [1:0] op, input logic on,
                                   output dpit_result_t status);
    logic refused;
    logic cool_fresh;
    refused    = 1'b0;
    cool_fresh = 1'b0;
    case (op)
      OP_TICK: begin
        if ((acid_on || base_on) && armed) begin
          if (run_cnt != TickMax) run_cnt = run_cnt + TickW'(1);
          if (run_cnt >= run_limit) begin
            halt_model();
            cool_fresh = in_cool && (cool_cnt == '0);
          end
        end
        if (in_cool) begin
          if (!cool_fresh && cool_cnt != TickMax) cool_cnt = cool_cnt + TickW'(1);
          if (cool_cnt >= cool_limit) begin
            in_cool  = 1'b0;
            cool_cnt = '0;
          end
        end
      end
      OP_ACID, OP_BASE: begin
        if (on && in_cool) begin
          refused = 1'b1;
        end else if (on) begin
          acid_on = (op == OP_ACID);
          base_on = (op == OP_BASE);
          run_cnt = '0;
          armed   = 1'b1;
        end else if (op == OP_ACID) begin
          acid_on = 1'b0;
        end else begin
          base_on = 1'b0;
        end
      end
      default: halt_model();
    endcase
    status.acid_drive      = acid_on;
    status.base_drive      = base_on;
    status.cooling_down    = in_cool;
    status.cooldown_left   = (in_cool && cool_cnt < cool_limit) ? cool_limit - cool_cnt : '0;
    status.request_refused = refused;
    if (refused) refusals++;
  endtask

  // One input transfer; entered and left at a falling edge
  task automatic send_item(input logic [1:0] op, input logic on);
    int unsigned gap;
    dpit_result_t status;
    gap = $urandom_range(0, idle_cap);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_turn_on <= on;
    do @(posedge clk); while (in_stall);
    advance_interlock(op, on, status);
    pending_status.push_back(status);
    items_fed++;
    @(negedge clk);
  endtask

  // Hold off until every outstanding status has come back
  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    settle_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RUN_TICKS) run_limit = val;
    else cool_limit = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Out of reset: cooling down at reset limits, turn-on refused
  task automatic test_reset_state();
    send_item(OP_ACID, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_STOP, 1'b0);
    write_reg(CFG_RUN_TICKS, 20'd4);
    write_reg(CFG_COOL_TICKS, 20'd2);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
  endtask

  // Mutual exclusion, switch-over, refusals and turn-off during cooldown
  task automatic test_interlock();
    send_item(OP_ACID, 1'b1);
    send_item(OP_BASE, 1'b1);
    send_item(OP_BASE, 1'b0);
    send_item(OP_ACID, 1'b1);
    send_item(OP_STOP, 1'b1);
    send_item(OP_ACID, 1'b0);
    send_item(OP_BASE, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
  endtask

  // Automatic stop when the run time is up; cooldown starts that same tick
  task automatic test_auto_stop();
    send_item(OP_ACID, 1'b1);
    repeat (4) send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
  endtask

  // Shorter run limit written while a pump runs; stop with nothing started
  task automatic test_limit_change();
    send_item(OP_BASE, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    write_reg(CFG_RUN_TICKS, 20'd1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_STOP, 1'b1);
  endtask

  // Zero limits: stop on the first tick, with no cooldown after it
  task automatic test_zero_limits();
    write_reg(CFG_RUN_TICKS, '0);
    write_reg(CFG_COOL_TICKS, '0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_ACID, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_BASE, 1'b1);
    send_item(OP_TICK, 1'b0);
  endtask

  // Full-scale limits
  task automatic test_register_extremes();
    write_reg(CFG_RUN_TICKS, TickMax);
    write_reg(CFG_COOL_TICKS, TickMax);
    send_item(OP_BASE, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_STOP, 1'b0);
    send_item(OP_TICK, 1'b0);
    write_reg(CFG_COOL_TICKS, '0);
    send_item(OP_TICK, 1'b0);
  endtask

  // Random dosing traffic, biased by the model's cooldown state
  task automatic test_random_dosing();
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    logic [1:0]  op;
    logic        on;
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 3) begin
        write_reg(CFG_RUN_TICKS, 20'($urandom_range(30, 80)));
        write_reg(CFG_COOL_TICKS, 20'($urandom_range(20, 60)));
      end else begin
        write_reg(CFG_RUN_TICKS, 20'($urandom_range(0, 12)));
        write_reg(CFG_COOL_TICKS, 20'($urandom_range(0, 10)));
      end
      for (n = 0; n < 145; n++) begin
        if (n % 50 == 0) begin
          pick = $urandom_range(0, 2);
          idle_cap = (pick == 0) ? 0 : (pick == 1) ? 3 : 16;
        end
        if (n == 75) settle_results();
        pick = $urandom_range(0, 99);
        on   = 1'($urandom_range(0, 1));
        if (in_cool) begin
          if (pick < 65) op = OP_TICK;
          else if (pick < 88) op = $urandom_range(0, 1) ? OP_ACID : OP_BASE;
          else op = OP_STOP;
          if (pick >= 65 && pick < 75) on = 1'b1;
        end else begin
          if (pick < 40) op = OP_TICK;
          else if (pick < 82) op = $urandom_range(0, 1) ? OP_ACID : OP_BASE;
          else op = OP_STOP;
          if (pick >= 40 && pick < 70) on = 1'b1;
        end
        send_item(op, on);
      end
      idle_cap = 16;
    end
  endtask

  // Result side: random stall before each transfer
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, idle_cap);
      while (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  // Compare each result transfer with the oldest expected status
  dpit_result_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("result transfer with no status expected");
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        status_checked++;
        if (out_acid_drive !== want.acid_drive) begin
          $error("acid_drive: expected %0d, got %0d", want.acid_drive, out_acid_drive);
          fail_count++;
        end
        if (out_base_drive !== want.base_drive) begin
          $error("base_drive: expected %0d, got %0d", want.base_drive, out_base_drive);
          fail_count++;
        end
        if (out_cooling_down !== want.cooling_down) begin
          $error("cooling_down: expected %0d, got %0d", want.cooling_down, out_cooling_down);
          fail_count++;
        end
        if (out_cooldown_left !== want.cooldown_left) begin
          $error("cooldown_left: expected %0d, got %0d", want.cooldown_left,
                 out_cooldown_left);
          fail_count++;
        end
        if (out_request_refused !== want.request_refused) begin
          $error("request_refused: expected %0d, got %0d", want.request_refused,
                 out_request_refused);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned guard;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_TICK;
    in_turn_on     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_RUN_TICKS;
    cfg_data       = '0;
    idle_cap       = 16;
    items_fed      = 0;
    status_checked = 0;
    refusals       = 0;
    reg_writes     = 0;
    fail_count     = 0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_interlock();
    test_auto_stop();
    test_limit_change();
    test_zero_limits();
    test_register_extremes();
    test_random_dosing();

    // Drain, then allow the result and skid registers to settle
    in_valid <= 1'b0;
    guard = 0;
    while (pending_status.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_status.size() != 0) begin
      $error("%0d expected status transfers never arrived", pending_status.size());
      fail_count++;
    end

    $display("Fed %0d ticks and pump commands across %0d register writes,", items_fed,
             reg_writes);
    $display("checked %0d status transfers, %0d of them refused turn-on requests.",
             status_checked, refusals);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
